// ----- hdl/masked_suv_stats_accumulator_defines.svh -----
// Assertion macros used by the checker of the statistics accumulator.
`ifndef MASKED_SUV_STATS_ACCUMULATOR_DEFINES_SVH
`define MASKED_SUV_STATS_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define MSSA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// The same, also checked while reset is applied.
`define MSSA_ASSERT_NEXT_ALWAYS(label, pre, post, msg) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hdl/mssa_pkg.sv -----
`timescale 1ns / 1ps

package mssa_pkg;

  localparam int FACTOR_FRAC_BITS_DEFAULT = 24;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTED_MASK = 1'b1;

  localparam logic [31:0] SCALE_FACTOR_RESET = 32'h0100_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_AS,
    S_MUL_FACTOR,
    S_FORM,
    S_SQUARE,
    S_WV,
    S_WSQ_LO,
    S_WSQ_HI,
    S_ACC,
    S_SUMSQ,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MUL_ACT_SLOPE,
    MUL_FACTOR,
    MUL_SQUARE,
    MUL_WV,
    MUL_WSQ_LO,
    MUL_WSQ_HI
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    mul_op_t mul_op;
    logic    form;
    logic    cap_sq;
    logic    cap_wv;
    logic    cap_wsq_lo;
    logic    accumulate;
    logic    sumsq;
    logic    emit;
  } ctrl_t;

  typedef struct packed {
    logic pixel_include;
    logic pixel_last;
    logic last;
  } status_t;

endpackage

// ----- hdl/mssa_controller.sv -----
`timescale 1ns / 1ps

module mssa_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  output logic              result_valid,
  input  logic              result_stall,
  input  mssa_pkg::status_t status,
  output mssa_pkg::ctrl_t   ctrl
);
  import mssa_pkg::*;

  state_t state;
  state_t state_next;
  logic   result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    ctrl.mul_op = MUL_ACT_SLOPE;
    pixel_stall = 1'b1;
    case (state)
      S_IDLE: begin
        pixel_stall = 1'b0;
        if (pixel_valid) begin
          ctrl.load = 1'b1;
          if (status.pixel_include) begin
            state_next = S_MUL_AS;
          end else if (status.pixel_last) begin
            state_next = S_EMIT;
          end
        end
      end
      S_MUL_AS: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MUL_ACT_SLOPE;
        state_next = S_MUL_FACTOR;
      end
      S_MUL_FACTOR: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MUL_FACTOR;
        state_next = S_FORM;
      end
      S_FORM: begin
        ctrl.form = 1'b1;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MUL_SQUARE;
        state_next = S_WV;
      end
      S_WV: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MUL_WV;
        ctrl.cap_sq = 1'b1;
        state_next = S_WSQ_LO;
      end
      S_WSQ_LO: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MUL_WSQ_LO;
        ctrl.cap_wv = 1'b1;
        state_next = S_WSQ_HI;
      end
      S_WSQ_HI: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MUL_WSQ_HI;
        ctrl.cap_wsq_lo = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        ctrl.accumulate = 1'b1;
        state_next = S_SUMSQ;
      end
      S_SUMSQ: begin
        ctrl.sumsq = 1'b1;
        state_next = status.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!(result_valid && result_stall)) begin
          ctrl.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    result_valid_next = ctrl.emit || (result_valid && result_stall);
  end

endmodule

// ----- hdl/mssa_datapath.sv -----
`timescale 1ns / 1ps

module mssa_datapath #(
  parameter int FACTOR_FRAC_BITS = mssa_pkg::FACTOR_FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mssa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mssa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             first,
  input  logic                             is_last,
  input  logic [15:0]                      activity,
  input  logic [15:0]                      slope,
  input  logic [15:0]                      mask_value,
  input  mssa_pkg::ctrl_t                  ctrl,
  output mssa_pkg::status_t                status,
  output logic [31:0]                      peak_value,
  output logic [63:0]                      total_sum,
  output logic [63:0]                      total_sum_squares,
  output logic [63:0]                      total_weight
);
  import mssa_pkg::*;

  localparam int SHR = (FACTOR_FRAC_BITS >= 16) ? FACTOR_FRAC_BITS - 16 : 0;
  localparam int SHL = (FACTOR_FRAC_BITS < 16) ? 16 - FACTOR_FRAC_BITS : 0;
  localparam int OVF_SHIFT = 32 + SHR - SHL;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  logic [31:0] scale_factor;
  logic        weighted_mask;

  logic [15:0] act_r;
  logic [15:0] slope_r;
  logic [15:0] mask_r;
  logic        last_r;

  logic [63:0] mul_res;
  logic [31:0] v_r;
  logic [47:0] sq_r;
  logic [47:0] wv_r;
  logic [47:0] wsq_lo_r;
  logic [63:0] wsq_r;

  logic [31:0] peak_reg;
  logic [63:0] sum_reg;
  logic [63:0] sum_squares_reg;
  logic [63:0] weight_reg;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [15:0] weight;
  logic [63:0] shifted;
  logic        ovf;
  logic [31:0] form_v;
  logic [63:0] wsq;

  assign status.pixel_include = (mask_value != 16'd0);
  assign status.pixel_last = is_last;
  assign status.last = last_r;

  assign weight = weighted_mask ? mask_r : 16'd1;

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (ctrl.mul_op)
      MUL_ACT_SLOPE: begin
        mul_a = {16'd0, act_r};
        mul_b = {16'd0, slope_r};
      end
      MUL_FACTOR: begin
        mul_a = scale_factor;
        mul_b = mul_res[31:0];
      end
      MUL_SQUARE: begin
        mul_a = v_r;
        mul_b = v_r;
      end
      MUL_WV: begin
        mul_a = v_r;
        mul_b = {16'd0, weight};
      end
      MUL_WSQ_LO: begin
        mul_a = sq_r[31:0];
        mul_b = {16'd0, weight};
      end
      MUL_WSQ_HI: begin
        mul_a = {16'd0, sq_r[47:32]};
        mul_b = {16'd0, weight};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_comb begin
    ovf = (mul_res >> OVF_SHIFT) != 64'd0;
    shifted = (mul_res >> SHR) << SHL;
    form_v = ovf ? '1 : shifted[31:0];
    wsq = {mul_res[31:0], 32'd0} + {16'd0, wsq_lo_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= SCALE_FACTOR_RESET;
      weighted_mask <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCALE_FACTOR: begin
          scale_factor <= cfg_data[31:0];
        end
        REG_WEIGHTED_MASK: begin
          weighted_mask <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_reg <= 32'd0;
      sum_reg <= 64'd0;
      sum_squares_reg <= 64'd0;
      weight_reg <= 64'd0;
    end else begin
      if (ctrl.load && first) begin
        peak_reg <= 32'd0;
        sum_reg <= 64'd0;
        sum_squares_reg <= 64'd0;
        weight_reg <= 64'd0;
      end
      if (ctrl.form && (form_v > peak_reg)) begin
        peak_reg <= form_v;
      end
      if (ctrl.accumulate) begin
        sum_reg <= sat_add(sum_reg, {16'd0, wv_r});
        weight_reg <= sat_add(weight_reg, {48'd0, weight});
      end
      if (ctrl.sumsq) begin
        sum_squares_reg <= sat_add(sum_squares_reg, wsq_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      act_r <= activity;
      slope_r <= slope;
      mask_r <= mask_value;
      last_r <= is_last;
    end
    if (ctrl.mul_en) begin
      mul_res <= {32'd0, mul_a} * {32'd0, mul_b};
    end
    if (ctrl.form) begin
      v_r <= form_v;
    end
    if (ctrl.cap_sq) begin
      sq_r <= mul_res[63:16];
    end
    if (ctrl.cap_wv) begin
      wv_r <= mul_res[47:0];
    end
    if (ctrl.cap_wsq_lo) begin
      wsq_lo_r <= mul_res[47:0];
    end
    if (ctrl.accumulate) begin
      wsq_r <= wsq;
    end
    if (ctrl.emit) begin
      peak_value <= peak_reg;
      total_sum <= sum_reg;
      total_sum_squares <= sum_squares_reg;
      total_weight <= weight_reg;
    end
  end

endmodule

// ----- hdl/masked_suv_stats_accumulator.sv -----
`timescale 1ns / 1ps

// Masked statistics accumulator: each pixel request carries activity, slope and mask, and the
// block keeps the peak, sum, sum of squares and weight of the included pixels, emitting them
// as one result request after a pixel marked last. All products go through one shared 32 by
// 32 multiplier, six of them per included pixel, stepped by the controller. A new pixel is
// taken only in the idle state: an included pixel holds the block until its results are
// accumulated, a masked-out pixel that is not last does not hold it, and a last pixel makes
// the block load the result register once no previous result is still stalled.
module masked_suv_stats_accumulator #(
  parameter int FACTOR_FRAC_BITS = mssa_pkg::FACTOR_FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mssa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mssa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  logic                             first,
  input  logic                             is_last,
  input  logic [15:0]                      activity,
  input  logic [15:0]                      slope,
  input  logic [15:0]                      mask_value,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [31:0]                      peak_value,
  output logic [63:0]                      total_sum,
  output logic [63:0]                      total_sum_squares,
  output logic [63:0]                      total_weight
);
  import mssa_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  mssa_controller u_controller (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .ctrl         (ctrl)
  );

  mssa_datapath #(
    .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .first             (first),
    .is_last           (is_last),
    .activity          (activity),
    .slope             (slope),
    .mask_value        (mask_value),
    .ctrl              (ctrl),
    .status            (status),
    .peak_value        (peak_value),
    .total_sum         (total_sum),
    .total_sum_squares (total_sum_squares),
    .total_weight      (total_weight)
  );

endmodule

// ----- hdl/mssa_checker.sv -----
`timescale 1ns / 1ps
`include "masked_suv_stats_accumulator_defines.svh"

module mssa_checker (
  input logic        clk,
  input logic        rst,
  input logic        pixel_valid,
  input logic        pixel_stall,
  input logic [15:0] mask_value,
  input logic        result_valid,
  input logic        result_stall,
  input logic [31:0] peak_value,
  input logic [63:0] total_sum,
  input logic [63:0] total_sum_squares,
  input logic [63:0] total_weight
);

  `MSSA_ASSERT_NEXT_ALWAYS(a_reset_clears_result, rst, !result_valid, "Result valid after reset.")

  `MSSA_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid, "Result dropped.")

  `MSSA_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(peak_value) && $stable(total_sum) && $stable(total_sum_squares) && $stable(total_weight), "Stalled result changed.")

  `MSSA_ASSERT_NEXT(a_busy_after_include, pixel_valid && !pixel_stall && (mask_value != 16'd0), pixel_stall, "Included pixel did not occupy the block.")

endmodule

bind masked_suv_stats_accumulator mssa_checker u_checker (.*);

// ----- tb/tb_masked_suv_stats_accumulator.sv -----
`timescale 1ns / 1ps

module tb_masked_suv_stats_accumulator;
  import mssa_pkg::*;

  localparam int VALUE_SHIFT = FACTOR_FRAC_BITS_DEFAULT - 16;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 24;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic        first;
    logic        last;
    logic [15:0] activity;
    logic [15:0] slope;
    logic [15:0] mask;
  } pixel_t;

  typedef struct packed {
    logic [31:0] peak;
    logic [63:0] sum;
    logic [63:0] sum_sq;
    logic [63:0] weight;
  } stats_t;

  typedef struct packed {
    bit          reconfig;
    logic [31:0] scale;
    bit          weighted;
    pixel_t      px;
    bit          typed;
    stats_t      want;
  } vector_t;

  // Rows with typed totals are checked against those values; the others use the predictor.
  localparam vector_t DIRECTED_ROWS [17] = '{
    '{1'b0, 32'h0, 1'b0, '{1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000},
      1'b1, '{32'h0, 64'h0, 64'h0, 64'h0}},
    '{1'b0, 32'h0, 1'b0, '{1'b1, 1'b1, 16'h0001, 16'h0001, 16'h0001},
      1'b1, '{32'h0001_0000, 64'h1_0000, 64'h1_0000, 64'h1}},
    '{1'b0, 32'h0, 1'b0, '{1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{1'b0, 32'h0, 1'b0, '{1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0001}, 1'b0, '0},
    '{1'b0, 32'h0, 1'b0, '{1'b1, 1'b1, 16'h1234, 16'h0042, 16'h0000}, 1'b1, '0},
    '{1'b0, 32'h0, 1'b0, '{1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1, '0},
    '{1'b0, 32'h0, 1'b0, '{1'b1, 1'b0, 16'hAAAA, 16'h5555, 16'h5555}, 1'b0, '0},
    '{1'b0, 32'h0, 1'b0, '{1'b0, 1'b1, 16'h5555, 16'hAAAA, 16'hAAAA}, 1'b0, '0},
    '{1'b1, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{1'b0, 32'h0, 1'b0, '{1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      1'b1, '{32'hFFFF_FFFF, 64'h0001_FFFD_FFFE_0002, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1_FFFE}},
    '{1'b0, 32'h0, 1'b0, '{1'b0, 1'b1, 16'h00FF, 16'h0100, 16'h8000}, 1'b0, '0},
    '{1'b1, 32'h0, 1'b1, '{1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0003},
      1'b1, '{32'h0, 64'h0, 64'h0, 64'h3}},
    '{1'b1, 32'h1, 1'b0, '{1'b1, 1'b0, 16'h0100, 16'h0100, 16'h0001}, 1'b0, '0},
    '{1'b0, 32'h0, 1'b0, '{1'b0, 1'b1, 16'h00FF, 16'h00FF, 16'hFFFF}, 1'b0, '0},
    '{1'b1, 32'h0100_0000, 1'b0, '{1'b1, 1'b1, 16'h0003, 16'h0005, 16'h0007},
      1'b1, '{32'h000F_0000, 64'hF_0000, 64'hE1_0000, 64'h1}},
    '{1'b0, 32'h0, 1'b0, '{1'b1, 1'b0, 16'h8000, 16'h0002, 16'h0001}, 1'b0, '0},
    '{1'b0, 32'h0, 1'b0, '{1'b0, 1'b1, 16'hFFFF, 16'h0001, 16'h0100}, 1'b0, '0}
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   pixel_valid;
  logic                   pixel_stall;
  logic                   first;
  logic                   is_last;
  logic [15:0]            activity;
  logic [15:0]            slope;
  logic [15:0]            mask_value;
  logic                   result_valid;
  logic                   result_stall;
  logic [31:0]            peak_value;
  logic [63:0]            total_sum;
  logic [63:0]            total_sum_squares;
  logic [63:0]            total_weight;

  logic [31:0] scale_q824 = SCALE_FACTOR_RESET;
  bit          weighted_mode = 1'b0;
  logic [31:0] peak_acc = '0;
  logic [63:0] sum_acc = '0;
  logic [63:0] sum_sq_acc = '0;
  logic [63:0] weight_acc = '0;

  stats_t pending_totals[$];
  int     mismatch_count = 0;
  int     counted_items = 0;
  int     burst_left = 0;
  bit     hold_req = 1'b0;

  masked_suv_stats_accumulator u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pixel_valid      (pixel_valid),
    .pixel_stall      (pixel_stall),
    .first            (first),
    .is_last          (is_last),
    .activity         (activity),
    .slope            (slope),
    .mask_value       (mask_value),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .peak_value       (peak_value),
    .total_sum        (total_sum),
    .total_sum_squares(total_sum_squares),
    .total_weight     (total_weight)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] saturating_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[64] ? 64'hFFFF_FFFF_FFFF_FFFF : total[63:0];
  endfunction

  function automatic logic [31:0] calibrated_value(logic [15:0] act, logic [15:0] slp);
    logic [31:0] act_slope;
    logic [63:0] product;
    act_slope = {16'd0, act} * {16'd0, slp};
    product = ({32'd0, scale_q824} * {32'd0, act_slope}) >> VALUE_SHIFT;
    return (product[63:32] != 0) ? 32'hFFFF_FFFF : product[31:0];
  endfunction

  task automatic accumulate_pixel(input pixel_t px, output bit emits, output stats_t totals);
    logic [31:0] value;
    logic [63:0] weight;
    logic [63:0] square;
    if (px.first) begin
      peak_acc = '0;
      sum_acc = '0;
      sum_sq_acc = '0;
      weight_acc = '0;
    end
    if (px.mask != 0) begin
      value = calibrated_value(px.activity, px.slope);
      weight = weighted_mode ? {48'd0, px.mask} : 64'd1;
      square = ({32'd0, value} * {32'd0, value}) >> 16;
      if (value > peak_acc) begin
        peak_acc = value;
      end
      sum_acc = saturating_add(sum_acc, weight * {32'd0, value});
      sum_sq_acc = saturating_add(sum_sq_acc, weight * square);
      weight_acc = saturating_add(weight_acc, weight);
    end
    emits = px.last;
    totals = '{peak_acc, sum_acc, sum_sq_acc, weight_acc};
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'h0000;
      default: return 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic offer_pixel(input pixel_t px, input bit typed, input stats_t typed_want);
    stats_t predicted;
    bit     emits;
    if (burst_left == 0) begin
      pixel_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    first = px.first;
    is_last = px.last;
    activity = px.activity;
    slope = px.slope;
    mask_value = px.mask;
    pixel_valid = 1'b1;
    do @(posedge clk); while (pixel_stall);
    accumulate_pixel(px, emits, predicted);
    if (emits) begin
      pending_totals.push_back(typed ? typed_want : predicted);
    end
    counted_items++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic quiesce();
    pixel_valid = 1'b0;
    burst_left = 0;
    while (pending_totals.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [31:0] scale, input bit weighted);
    quiesce();
    cfg_write = 1'b1;
    cfg_index = REG_SCALE_FACTOR;
    cfg_data = scale;
    @(negedge clk);
    cfg_index = REG_WEIGHTED_MASK;
    cfg_data = {{(CFG_DATA_W - 1){1'b0}}, weighted};
    @(negedge clk);
    cfg_write = 1'b0;
    scale_q824 = scale;
    weighted_mode = weighted;
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    stats_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_totals.size() == 0) begin
        $error("result request with no totals expected");
        mismatch_count++;
      end else begin
        want = pending_totals.pop_front();
        check_field("peak_value", {32'd0, want.peak}, {32'd0, peak_value});
        check_field("total_sum", want.sum, total_sum);
        check_field("total_sum_squares", want.sum_sq, total_sum_squares);
        check_field("total_weight", want.weight, total_weight);
      end
    end
  end

  // The result side stalls in random modes, and once holds off for a long stretch on demand.
  initial begin : result_sink
    int mode_left;
    int stall_pct;
    mode_left = 0;
    stall_pct = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 80);
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 30;
            default: stall_pct = 75;
          endcase
        end
        mode_left--;
        result_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    pixel_t      px;
    logic [31:0] scale;
    int          phase;
    int          frame_len;
    bit          broken;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixel_valid = 1'b0;
    first = 1'b0;
    is_last = 1'b0;
    activity = '0;
    slope = '0;
    mask_value = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].reconfig) begin
        configure(DIRECTED_ROWS[i].scale, DIRECTED_ROWS[i].weighted);
      end
      offer_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    counted_items = 0;
    phase = 0;
    while (counted_items < RANDOM_ITEMS) begin
      scale = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 7) == 0) begin
        scale = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      end
      configure(scale, 1'($urandom_range(0, 1)));
      // While results are held off, a run of single-pixel frames backs the block up.
      if (phase == 1) begin
        hold_req = 1'b1;
        repeat (40) begin
          px = '{1'b1, 1'b1, random_sample(), random_sample(), 16'($urandom_range(1, 65535))};
          offer_pixel(px, 1'b0, '0);
        end
      end
      repeat ($urandom_range(4, 12)) begin
        frame_len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < frame_len; k++) begin
          px.first = broken ? 1'($urandom_range(0, 1)) : (k == 0);
          px.last = broken ? ($urandom_range(0, 3) == 0) : (k == frame_len - 1);
          px.activity = random_sample();
          px.slope = random_sample();
          px.mask = ($urandom_range(0, 4) == 0) ? 16'h0000 : random_sample();
          offer_pixel(px, 1'b0, '0);
        end
      end
      phase++;
    end

    quiesce();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/mssa_pkg.sv
hdl/mssa_controller.sv
hdl/mssa_datapath.sv
hdl/masked_suv_stats_accumulator.sv
hdl/mssa_checker.sv
tb/tb_masked_suv_stats_accumulator.sv
